>>> rtl/rrp_pkg.sv
// Shared types and constants for the RESP2 reply parser.
// Used by rrp_step and resp_reply_parser; depends on nothing.
package rrp_pkg;

    // Reply grammar characters
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int unsigned NUM_W = 31;   // magnitude width of any number
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // Result kinds
    typedef enum logic [3:0] {
        K_STATUS_BYTE = 4'd0,
        K_ERROR_BYTE  = 4'd1,
        K_BULK_BYTE   = 4'd2,
        K_STATUS_END  = 4'd3,
        K_ERROR_END   = 4'd4,
        K_INTEGER     = 4'd5,
        K_NULL_BULK   = 4'd6,
        K_BULK_END    = 4'd7,
        K_ARRAY_HDR   = 4'd8,
        K_PROTO_ERR   = 4'd9
    } t_kind;

    // Parser position within a reply
    typedef enum logic [2:0] {
        M_START,
        M_STATUS,
        M_ERRLINE,
        M_NUM,
        M_BULK_DATA,
        M_BULK_TRAIL
    } t_mode;

    // What a number being read is for
    typedef enum logic [1:0] {
        P_INT,
        P_BLEN,
        P_ALEN
    } t_purpose;

    // Where we are inside a number
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SIGNED,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data_byte;
        logic [31:0]        value;
        logic [NUM_W-1:0]   element_index;
        logic               last_of_reply;
    } t_result;

endpackage

>>> rtl/rrp_step.sv
// Per-byte parse step: parser state registers and next-state/result logic.
// Depends on rrp_pkg.
module rrp_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_emit,
    output rrp_pkg::t_result o_res
);
    import rrp_pkg::*;

    t_mode            r_mode, n_mode;
    t_purpose         r_purpose, n_purpose;
    t_phase           r_phase, n_phase;
    logic [NUM_W-1:0] r_accum, n_accum;
    logic             r_neg, n_neg;
    logic [NUM_W-1:0] r_bulk_rem, n_bulk_rem;
    logic [NUM_W-1:0] r_elem_left, n_elem_left;
    logic [NUM_W-1:0] r_elem_cnt, n_elem_cnt;
    logic             r_in_array, n_in_array;
    logic             r_cr, n_cr;
    logic             r_failed, n_failed;

    logic             is_digit;
    logic [3:0]       digit;
    logic [NUM_W+3:0] acc_x10;
    logic             overflow;
    logic             fin_elem;
    t_kind            fin_kind;
    logic             elem_last;

    // Decimal accumulate: acc*10 + d, overflow past 31 bits is an error
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = 4'(i_byte - CH_ZERO);
    assign acc_x10  = ({3'b000, r_accum, 1'b0} + {1'b0, r_accum, 3'b000})
                      + {{NUM_W{1'b0}}, digit};
    assign overflow = (acc_x10 > {4'b0000, NUM_MAX});
    assign elem_last = (r_elem_left == {{(NUM_W-1){1'b0}}, 1'b1});

    // Next state and result
    always_comb begin
        n_mode      = r_mode;
        n_purpose   = r_purpose;
        n_phase     = r_phase;
        n_accum     = r_accum;
        n_neg       = r_neg;
        n_bulk_rem  = r_bulk_rem;
        n_elem_left = r_elem_left;
        n_elem_cnt  = r_elem_cnt;
        n_in_array  = r_in_array;
        n_cr        = r_cr;
        n_failed    = r_failed;
        o_emit      = 1'b0;
        fin_elem    = 1'b0;
        fin_kind    = K_BULK_END;
        o_res.kind          = K_PROTO_ERR;
        o_res.data_byte     = 8'h00;
        o_res.value         = 32'h0;
        o_res.element_index = r_in_array ? r_elem_cnt : '0;
        o_res.last_of_reply = 1'b1;

        if (!r_failed) begin
            unique case (r_mode)
                M_START: begin
                    n_cr    = 1'b0;
                    n_accum = '0;
                    n_neg   = 1'b0;
                    n_phase = PH_FIRST;
                    if (i_byte == CH_DOLLAR) begin
                        n_mode    = M_NUM;
                        n_purpose = P_BLEN;
                    end else if (r_in_array) begin
                        n_failed = 1'b1;
                        o_emit   = 1'b1;
                    end else if (i_byte == CH_STAR) begin
                        n_mode    = M_NUM;
                        n_purpose = P_ALEN;
                    end else if (i_byte == CH_COLON) begin
                        n_mode    = M_NUM;
                        n_purpose = P_INT;
                    end else if (i_byte == CH_PLUS) begin
                        n_mode = M_STATUS;
                    end else if (i_byte == CH_MINUS) begin
                        n_mode = M_ERRLINE;
                    end else begin
                        n_failed = 1'b1;
                        o_emit   = 1'b1;
                    end
                end
                M_STATUS, M_ERRLINE: begin
                    o_emit = 1'b1;
                    if (r_cr) begin
                        if (i_byte != CH_LF) begin
                            n_failed = 1'b1;
                        end else begin
                            n_cr       = 1'b0;
                            n_mode     = M_START;
                            o_res.kind = (r_mode == M_STATUS) ? K_STATUS_END : K_ERROR_END;
                        end
                    end else if (i_byte == CH_CR) begin
                        n_cr   = 1'b1;
                        o_emit = 1'b0;
                    end else if (i_byte == CH_LF) begin
                        n_failed = 1'b1;
                    end else begin
                        o_res.kind = (r_mode == M_STATUS) ? K_STATUS_BYTE : K_ERROR_BYTE;
                        o_res.data_byte     = i_byte;
                        o_res.last_of_reply = 1'b0;
                    end
                end
                M_NUM: begin
                    if (r_cr) begin
                        if (i_byte != CH_LF) begin
                            n_failed = 1'b1;
                            o_emit   = 1'b1;
                        end else begin
                            // line complete: act on the number
                            n_cr   = 1'b0;
                            n_mode = M_START;
                            if (r_purpose == P_INT) begin
                                o_emit      = 1'b1;
                                o_res.kind  = K_INTEGER;
                                o_res.value = r_neg ? (32'h0 - {1'b0, r_accum})
                                                    : {1'b0, r_accum};
                            end else if (r_neg && r_accum == NUM_W'(1)) begin
                                if (r_purpose == P_BLEN) begin
                                    fin_elem = 1'b1;
                                    fin_kind = K_NULL_BULK;
                                end else begin
                                    o_emit      = 1'b1;
                                    o_res.kind  = K_ARRAY_HDR;
                                    o_res.value = 32'hFFFF_FFFF;
                                end
                            end else if (r_neg && r_accum != '0) begin
                                n_failed = 1'b1;
                                o_emit   = 1'b1;
                            end else if (r_purpose == P_BLEN) begin
                                n_bulk_rem = r_accum;
                                n_mode = (r_accum == '0) ? M_BULK_TRAIL : M_BULK_DATA;
                            end else begin
                                o_emit      = 1'b1;
                                o_res.kind  = K_ARRAY_HDR;
                                o_res.value = {1'b0, r_accum};
                                if (r_accum != '0) begin
                                    o_res.last_of_reply = 1'b0;
                                    n_in_array  = 1'b1;
                                    n_elem_left = r_accum;
                                    n_elem_cnt  = '0;
                                end
                            end
                        end
                    end else if (i_byte == CH_CR) begin
                        if (r_phase != PH_DIGITS) begin
                            n_failed = 1'b1;
                            o_emit   = 1'b1;
                        end else begin
                            n_cr = 1'b1;
                        end
                    end else if (i_byte == CH_MINUS && r_phase == PH_FIRST) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGNED;
                    end else if (is_digit && !overflow) begin
                        n_accum = acc_x10[NUM_W-1:0];
                        n_phase = PH_DIGITS;
                    end else begin
                        n_failed = 1'b1;
                        o_emit   = 1'b1;
                    end
                end
                M_BULK_DATA: begin
                    o_emit              = 1'b1;
                    o_res.kind          = K_BULK_BYTE;
                    o_res.data_byte     = i_byte;
                    o_res.last_of_reply = 1'b0;
                    n_bulk_rem          = r_bulk_rem - NUM_W'(1);
                    if (r_bulk_rem == NUM_W'(1)) begin
                        n_mode = M_BULK_TRAIL;
                    end
                end
                M_BULK_TRAIL: begin
                    if (r_cr) begin
                        if (i_byte != CH_LF) begin
                            n_failed = 1'b1;
                            o_emit   = 1'b1;
                        end else begin
                            n_cr     = 1'b0;
                            fin_elem = 1'b1;
                            fin_kind = K_BULK_END;
                        end
                    end else if (i_byte == CH_CR) begin
                        n_cr = 1'b1;
                    end else begin
                        n_failed = 1'b1;
                        o_emit   = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                    o_emit   = 1'b1;
                end
            endcase

            // End of a bulk element; counts down the enclosing array
            if (fin_elem) begin
                n_mode     = M_START;
                o_emit     = 1'b1;
                o_res.kind = fin_kind;
                if (r_in_array) begin
                    n_elem_left         = r_elem_left - NUM_W'(1);
                    o_res.last_of_reply = elem_last;
                    n_elem_cnt          = r_elem_cnt + NUM_W'(1);
                    if (elem_last) begin
                        n_in_array = 1'b0;
                        n_elem_cnt = '0;
                    end
                end
            end
        end
    end

    // State registers advance only when a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_START;
            r_purpose   <= P_INT;
            r_phase     <= PH_FIRST;
            r_accum     <= '0;
            r_neg       <= 1'b0;
            r_bulk_rem  <= '0;
            r_elem_left <= '0;
            r_elem_cnt  <= '0;
            r_in_array  <= 1'b0;
            r_cr        <= 1'b0;
            r_failed    <= 1'b0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_purpose   <= n_purpose;
            r_phase     <= n_phase;
            r_accum     <= n_accum;
            r_neg       <= n_neg;
            r_bulk_rem  <= n_bulk_rem;
            r_elem_left <= n_elem_left;
            r_elem_cnt  <= n_elem_cnt;
            r_in_array  <= n_in_array;
            r_cr        <= n_cr;
            r_failed    <= n_failed;
        end
    end

    // Once failed, the parser stays silent
    a_silent_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !o_emit)
        else $error("result produced after protocol error");

    // A reported protocol error latches the failed flag
    a_err_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_emit && o_res.kind == K_PROTO_ERR) |=> r_failed)
        else $error("protocol error did not latch");

    // Inside an array at least one element is still owed
    a_array_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_array |-> (r_elem_left != '0))
        else $error("array open with no elements left");

    // Element index is cleared outside arrays
    a_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_array |-> (r_elem_cnt == '0))
        else $error("element counter not cleared outside array");

endmodule

>>> rtl/resp_reply_parser.sv
// Top level of the RESP2 reply parser: input register, parse step, result register.
// Depends on rrp_pkg and rrp_step.
//
// Usage:
//   Input channel (i_valid / o_ready / i_byte_in) carries one reply byte per
//   request. Output channel (o_valid / i_ready) carries one parse result per
//   request: o_kind, o_data_byte, o_value, o_element_index, o_last_of_reply.
//   A byte yields zero or one result; line CRs, type bytes and length digits
//   yield none.
// Path: an accepted byte waits in the input register and is parsed out of it at
//   the edge that loads its result into the result register.
// Throughput: one byte per cycle while results are taken, set by the combinational
//   parse step between the input and result registers; bytes that give no result never wait.
// Stall: while a result waits on i_ready, one more byte is held in the input
//   register and o_ready drops only when that byte needs the result slot.
// Reset: i_rst_n (synchronous, active low) empties both registers and returns
//   the parser to the start of a reply. After a protocol error the parser
//   reports it once and then drops all bytes until reset.
module resp_reply_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_byte_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [3:0]                 o_kind,
    output logic [7:0]                 o_data_byte,
    output logic signed [31:0]         o_value,
    output logic [rrp_pkg::NUM_W-1:0]  o_element_index,
    output logic                       o_last_of_reply
);
    import rrp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       step_emit;
    t_result    step_res;
    logic       advance;

    rrp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_byte  (r_in_byte),
        .o_emit  (step_emit),
        .o_res   (step_res)
    );

    // Byte leaves the input register when its result has a place to go or it gives no result
    assign advance = r_in_valid && (!r_out_valid || i_ready || !step_emit);
    assign o_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_out <= step_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_data_byte     = r_out.data_byte;
    assign o_value         = r_out.value;
    assign o_element_index = r_out.element_index;
    assign o_last_of_reply = r_out.last_of_reply;

endmodule
